@@ rtl/raw_pixel_word_unpacker_assert.svh @@
// Assertion macros shared by the raw pixel word unpacker checker.
`ifndef RAW_PIXEL_WORD_UNPACKER_ASSERT_SVH
`define RAW_PIXEL_WORD_UNPACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RPWU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("raw pixel word unpacker: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RPWU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("raw pixel word unpacker: next-cycle check failed");

`endif

@@ rtl/rpwu_pkg.sv @@
// Shared constants, types and helpers of the raw pixel word unpacker.
package rpwu_pkg;

   localparam int BUS_BITS    = 32;
   localparam int MAX_RESULTS = 32;
   localparam int PIXEL_W     = 16;
   localparam int PBITS_W     = 5;
   localparam int LINE_W      = 16;
   localparam int LEFT_W      = $clog2(BUS_BITS + 1);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_BITS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_PIXELS = 1'b1;

   localparam logic [PBITS_W-1:0] PIXEL_BITS_RESET  = 5'd10;
   localparam logic [LINE_W-1:0]  LINE_PIXELS_RESET = 16'd1920;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic have_pixel;
      logic last_pixel;
      logic out_free;
   } status_type;

   // Width of one pixel as used by the datapath: zero reads as 1, above 16 as 16.
   function automatic logic [PBITS_W-1:0] clamp_bits(input logic [PBITS_W-1:0] raw);
      logic [PBITS_W-1:0] res;
      res = raw;
      if (raw == '0) begin
         res = PBITS_W'(1);
      end else if (raw > PBITS_W'(PIXEL_W)) begin
         res = PBITS_W'(PIXEL_W);
      end
      return res;
   endfunction

   // Mask of the k lowest bits of a pixel, k from 0 to 16.
   function automatic logic [PIXEL_W-1:0] low_mask(input logic [PBITS_W-1:0] k);
      logic [PIXEL_W:0] wide;
      wide = (PIXEL_W+1)'(1) << k;
      return PIXEL_W'(wide - (PIXEL_W+1)'(1));
   endfunction

endpackage

@@ rtl/rpwu_ctrl.sv @@
// Controller state machine of the raw pixel word unpacker.
module rpwu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  rpwu_pkg::status_type status,
   output rpwu_pkg::cmd_type    cmd
);
   import rpwu_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (!status.have_pixel) begin
               state_in = ST_IDLE;
            end else if (status.out_free && status.last_pixel) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_WORK: begin
            cmd.emit   = status.have_pixel && status.out_free;
            cmd.finish = !status.have_pixel;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/rpwu_datapath.sv @@
// Datapath of the raw pixel word unpacker: word shifter, carry, counters, output register.
module rpwu_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [rpwu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rpwu_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic [rpwu_pkg::BUS_BITS-1:0]          req_tdata,
   input  rpwu_pkg::cmd_type                      cmd,
   output rpwu_pkg::status_type                   status,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [rpwu_pkg::PIXEL_W-1:0]           rsp_tdata,
   output logic                                   rsp_tlast,
   output logic [0:0]                             rsp_tuser
);
   import rpwu_pkg::*;

   logic [PBITS_W-1:0]  pixel_bits_ff;
   logic [LINE_W-1:0]   line_pixels_ff;
   logic [BUS_BITS-1:0] word_ff;
   logic [LEFT_W-1:0]   left_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [PIXEL_W-1:0]  carry_bits_ff;
   logic [PBITS_W-1:0]  carry_count_ff;
   logic [LINE_W-1:0]   pixels_done_ff;
   logic                rsp_valid_ff;
   logic [PIXEL_W-1:0]  rsp_pixel_ff;
   logic                rsp_last_ff;
   logic                rsp_done_ff;

   logic [PBITS_W-1:0]  p;
   logic                join_pix;
   logic [PBITS_W-1:0]  take;
   logic [PIXEL_W-1:0]  pix_low;
   logic [PIXEL_W-1:0]  pix_val;
   logic [BUS_BITS-1:0] word_in;
   logic [LEFT_W-1:0]   left_in;
   logic [LINE_W-1:0]   done_inc;
   logic                line_end;
   logic                last_pixel;
   logic                carry_keep;
   logic [PIXEL_W-1:0]  keep_bits;
   logic [LEFT_W-1:0]   src_left;
   logic [BUS_BITS-1:0] src_word;

   assign p        = clamp_bits(pixel_bits_ff);
   assign join_pix = (carry_count_ff != '0);
   assign take     = join_pix ? (p - carry_count_ff) : p;
   assign pix_low  = word_ff[PIXEL_W-1:0] & low_mask(take);
   assign pix_val  = join_pix ? (PIXEL_W'(pix_low << carry_count_ff) | carry_bits_ff)
                              : pix_low;
   assign word_in  = word_ff >> take;
   assign left_in  = left_ff - LEFT_W'(take);
   assign done_inc = pixels_done_ff + LINE_W'(1);
   assign line_end = (done_inc == line_pixels_ff);
   assign last_pixel = line_end || (left_in < LEFT_W'(p))
                       || (count_ff == CNT_W'(MAX_RESULTS - 1));

   // Leftover bits kept for the next word, taken after a pixel or when none fits.
   assign src_left   = cmd.finish ? left_ff : left_in;
   assign src_word   = cmd.finish ? word_ff : word_in;
   assign carry_keep = (src_left != '0) && (src_left < LEFT_W'(p));
   assign keep_bits  = src_word[PIXEL_W-1:0] & low_mask(PBITS_W'(src_left));

   assign status.have_pixel = join_pix
                              || ((left_ff >= LEFT_W'(p))
                                  && (count_ff < CNT_W'(MAX_RESULTS)));
   assign status.last_pixel = last_pixel;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bits_ff  <= PIXEL_BITS_RESET;
         line_pixels_ff <= LINE_PIXELS_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_PIXEL_BITS) begin
            pixel_bits_ff <= csr_data[PBITS_W-1:0];
         end else if (csr_index == REG_LINE_PIXELS) begin
            line_pixels_ff <= csr_data[LINE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_bits_ff  <= '0;
         carry_count_ff <= '0;
         pixels_done_ff <= '0;
         left_ff        <= '0;
         count_ff       <= '0;
      end else begin
         if (cmd.load) begin
            left_ff  <= LEFT_W'(BUS_BITS);
            count_ff <= '0;
            if (!(join_pix && (carry_count_ff < p))) begin
               carry_bits_ff  <= '0;
               carry_count_ff <= '0;
            end
         end else if (cmd.emit) begin
            left_ff        <= left_in;
            count_ff       <= count_ff + CNT_W'(1);
            pixels_done_ff <= line_end ? '0 : done_inc;
            if (last_pixel && !line_end && carry_keep) begin
               carry_bits_ff  <= keep_bits;
               carry_count_ff <= PBITS_W'(src_left);
            end else if (join_pix || line_end || last_pixel) begin
               carry_bits_ff  <= '0;
               carry_count_ff <= '0;
            end
         end else if (cmd.finish) begin
            carry_bits_ff  <= carry_keep ? keep_bits : '0;
            carry_count_ff <= carry_keep ? PBITS_W'(src_left) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_tdata;
      end else if (cmd.emit) begin
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pixel_ff <= pix_val;
         rsp_last_ff  <= line_end;
         rsp_done_ff  <= last_pixel;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_pixel_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_done_ff;

endmodule

@@ rtl/raw_pixel_word_unpacker.sv @@
// Top level of the raw pixel word unpacker: controller and datapath joined.
// The block takes one 32-bit packed word per req transaction and hands out the pixels it
// holds, least significant bits first, one pixel per rsp transaction and at most one per
// cycle. A pixel whose bits straddle two words is completed with the low bits of the next
// word. Each pixel counts towards the configured line width; the pixel that closes a line
// carries rsp_tlast, the rest of its word is dropped and the next line starts on a fresh
// word. rsp_tuser marks the last pixel that a given word produces. A word is loaded first
// and its pixels are then shifted out one by one through the word register; a stalled rsp
// side holds them back. The block loads a new word only after the previous one has
// produced its last pixel, while that pixel may still wait in the output register.
// Configuration writes are always taken and should only be made while no word is being
// unpacked. A width of zero is treated as one bit, and a width above sixteen as sixteen
// bits; a line width of zero closes a line after 65536 pixels.
module raw_pixel_word_unpacker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rpwu_pkg::BUS_BITS-1:0]       req_tdata,   // [31:0] packed_word
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rpwu_pkg::PIXEL_W-1:0]        rsp_tdata,   // [15:0] pixel
   output logic                                rsp_tlast,   // line_end
   output logic [0:0]                          rsp_tuser,   // [0] word_done
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rpwu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rpwu_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rpwu_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Configuration registers accept a write transaction in every cycle.
   assign csr_ready = 1'b1;

   rpwu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rpwu_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/rpwu_checker.sv @@
// Port-level checker of the raw pixel word unpacker and its bind.
`include "raw_pixel_word_unpacker_assert.svh"

module rpwu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rpwu_pkg::PIXEL_W-1:0]    rsp_tdata,
   input logic                            rsp_tlast,
   input logic [0:0]                      rsp_tuser
);
   // A result held back by the consumer stays in place.
   `RPWU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // The pixel closing a line is always the last one its word gives.
   `RPWU_ASSERT_SAME(a_line_end_ends_word, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[0])
   // After a word is taken, the next one waits until unpacking has run.
   `RPWU_ASSERT_NEXT(a_one_word_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule

bind raw_pixel_word_unpacker rpwu_checker u_rpwu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
